// ===== hdl/c3zp_pkg.sv =====
// ----------------------------------------------------------------------------
// 3x3 zero-padded convolution - shared definitions
// Kernel codes, register indexes, the preset kernel table and the per-beat
// classification carried from the front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package c3zp_pkg;

    localparam int CONV_W      = 12;
    localparam int CFG_W       = 11;
    localparam int MODE_W      = 2;
    localparam int IDX_W       = 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [IDX_W-1:0] REG_KERNEL_MODE = 1'b0;
    localparam logic [IDX_W-1:0] REG_IMAGE_SIZE  = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_SIZE_RST = 11'd8;

    typedef enum logic [MODE_W-1:0] {
        KM_VERT  = 2'd0,
        KM_HORZ  = 2'd1,
        KM_SHARP = 2'd2,
        KM_BLUR  = 2'd3
    } t_kernel_mode;

    typedef logic signed [3:0] t_coef;

    // row-major, window row 0 is the oldest image row
    localparam t_coef KERNEL_TAB [4][9] = '{
        '{-4'sd1,  4'sd0,  4'sd1, -4'sd1,  4'sd0,  4'sd1, -4'sd1,  4'sd0,  4'sd1},
        '{-4'sd1, -4'sd1, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd1,  4'sd1},
        '{ 4'sd0, -4'sd1,  4'sd0, -4'sd1,  4'sd5, -4'sd1,  4'sd0, -4'sd1,  4'sd0},
        '{ 4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1}
    };

    typedef struct packed {
        logic have;
        logic last;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } t_cls;

endpackage

// ===== hdl/c3zp_front.sv =====
// ----------------------------------------------------------------------------
// 3x3 zero-padded convolution - front end
// Accepts beats, tracks the raster position, reads and updates the two row
// stores and classifies each beat (result or not, border masks, frame end).
// ----------------------------------------------------------------------------
module c3zp_front #(
    parameter int MAX_SIZE   = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic [c3zp_pkg::CFG_W-1:0]   i_image_size,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [PIXEL_BITS-1:0]        i_pixel,
    input  logic                         i_is_flush,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [PIXEL_BITS-1:0]        o_top,
    output logic [PIXEL_BITS-1:0]        o_mid,
    output logic [PIXEL_BITS-1:0]        o_pix,
    output c3zp_pkg::t_cls               o_cls
);
    import c3zp_pkg::*;

    localparam int CW = $clog2(MAX_SIZE + 1);
    localparam int RW = $clog2(MAX_SIZE + 2);
    localparam int AW = $clog2(MAX_SIZE);
    localparam int P  = PIXEL_BITS;

    logic [2*P-1:0]  mem [MAX_SIZE];

    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic            r_b_valid;
    logic [P-1:0]    r_b_pix;
    logic [AW-1:0]   r_b_idx;
    t_cls            r_b_cls;
    logic            r_fwd;
    logic [2*P-1:0]  r_fwd_word;
    logic [2*P-1:0]  r_rd;

    logic [CW-1:0]   size_eff, nm1_c, cc, col_inc;
    logic [RW-1:0]   nm1_r, cr;
    logic [P-1:0]    pix;
    logic [AW-1:0]   idx;
    t_cls            cls;
    logic            accept, b_move;
    logic [2*P-1:0]  b_word;

    always_comb begin
        if (i_image_size == '0) begin
            size_eff = CW'(1);
        end else if (32'(i_image_size) > 32'(MAX_SIZE)) begin
            size_eff = CW'(MAX_SIZE);
        end else begin
            size_eff = CW'(i_image_size);
        end
    end

    always_comb begin
        pix   = i_is_flush ? '0 : i_pixel;
        idx   = r_col[AW-1:0];
        nm1_c = size_eff - CW'(1);
        nm1_r = RW'(size_eff) - RW'(1);
        // window center is N+1 beats back
        if (r_col != '0) begin
            cr = r_row - RW'(1);
            cc = r_col - CW'(1);
        end else begin
            cr = r_row - RW'(2);
            cc = nm1_c;
        end
        cls.have     = ((r_row != '0) && (r_col != '0)) || (r_row >= RW'(2));
        cls.last     = (cr == nm1_r) && (cc == nm1_c);
        cls.top_ok   = (cr != '0);
        cls.bot_ok   = (cr != nm1_r);
        cls.left_ok  = (cc != '0);
        cls.right_ok = (cc != nm1_c);
        col_inc = r_col + CW'(1);
        if (cls.have && cls.last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= size_eff) begin
            n_col = '0;
            n_row = r_row + RW'(1);
        end else begin
            n_col = col_inc;
            n_row = r_row;
        end
    end

    assign b_move  = r_b_valid && i_ready;
    assign o_ready = !r_b_valid || b_move;
    assign accept  = i_valid && o_ready;
    assign b_word  = r_fwd ? r_fwd_word : r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (i_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_b_valid <= 1'b1;
                r_fwd     <= b_move && (r_b_idx == idx);
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix    <= pix;
            r_b_idx    <= idx;
            r_b_cls    <= cls;
            r_fwd_word <= {b_word[P-1:0], r_b_pix};
        end
    end

    // row store: upper row in the high half, lower row in the low half
    always_ff @(posedge i_clk) begin
        if (b_move) begin
            mem[r_b_idx] <= {b_word[P-1:0], r_b_pix};
        end
        if (accept) begin
            r_rd <= mem[idx];
        end
    end

    assign o_valid = r_b_valid;
    assign o_top   = b_word[2*P-1:P];
    assign o_mid   = b_word[P-1:0];
    assign o_pix   = r_b_pix;
    assign o_cls   = r_b_cls;

endmodule

// ===== hdl/c3zp_fifo.sv =====
// ----------------------------------------------------------------------------
// 3x3 zero-padded convolution - beat queue
// Small register FIFO between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module c3zp_fifo #(
    parameter int W     = 30,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    import c3zp_pkg::*;

    localparam int PTW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PTW-1:0] r_wr, r_rd;
    logic [PTW:0]   r_count;
    logic           push, pop;

    assign o_ready = (r_count != (PTW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + PTW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PTW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (PTW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (PTW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/c3zp_back.sv =====
// ----------------------------------------------------------------------------
// 3x3 zero-padded convolution - arithmetic back end
// Holds the 3x3 window, applies the border masks and the selected kernel,
// divides blur sums by nine and drives the result register.
// ----------------------------------------------------------------------------
module c3zp_back #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  c3zp_pkg::t_kernel_mode               i_mode,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [PIXEL_BITS-1:0]                i_top,
    input  logic [PIXEL_BITS-1:0]                i_mid,
    input  logic [PIXEL_BITS-1:0]                i_pix,
    input  c3zp_pkg::t_cls                       i_cls,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [c3zp_pkg::CONV_W-1:0]   o_conv_value,
    output logic                                 o_frame_end
);
    import c3zp_pkg::*;

    localparam int P     = PIXEL_BITS;
    localparam int SW    = P + 5;
    localparam int KW    = P + 4;
    localparam int DIV_S = KW + 4;
    localparam int MW    = DIV_S - 2;
    localparam int PW    = KW + MW;
    localparam int QW    = PW - DIV_S;
    localparam int EW    = (SW > CONV_W) ? SW : CONV_W;
    localparam int unsigned DIV_M = ((32'd1 << DIV_S) + 32'd8) / 32'd9;

    logic [P-1:0]         r_win [9];
    t_cls                 r_w_cls;
    logic                 r_w_have;
    logic signed [SW-1:0] r_rs [3];
    logic                 r_s2_have, r_s2_last;
    logic signed [SW-1:0] r_acc;
    logic                 r_s3_have, r_s3_last;
    logic [PW-1:0]        r_prod;
    logic signed [SW-1:0] r_acc4;
    logic                 r_s4_have, r_s4_last;
    logic                 r_out_valid, r_out_last;
    logic [CONV_W-1:0]    r_out_value;

    logic                 en, pop;
    logic signed [SW-1:0] term [9];
    logic signed [SW-1:0] res;
    logic signed [EW-1:0] ext;
    logic [QW-1:0]        quot;

    assign en      = !r_out_valid || i_ready;
    assign pop     = en && i_valid;
    assign o_ready = en;

    always_comb begin
        logic rok, cok;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                rok = (r == 0) ? r_w_cls.top_ok  : ((r == 2) ? r_w_cls.bot_ok   : 1'b1);
                cok = (c == 0) ? r_w_cls.left_ok : ((c == 2) ? r_w_cls.right_ok : 1'b1);
                if (rok && cok) begin
                    term[r*3+c] = SW'(KERNEL_TAB[i_mode][r*3+c]) *
                                  SW'(signed'({1'b0, r_win[r*3+c]}));
                end else begin
                    term[r*3+c] = '0;
                end
            end
        end
    end

    always_comb begin
        quot = r_prod[PW-1:DIV_S];
        if (i_mode == KM_BLUR) begin
            res = SW'(signed'({1'b0, quot}));
        end else begin
            res = r_acc4;
        end
        ext = EW'(res);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_have    <= 1'b0;
            r_s2_have   <= 1'b0;
            r_s3_have   <= 1'b0;
            r_s4_have   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_w_have    <= pop && i_cls.have;
            r_s2_have   <= r_w_have;
            r_s3_have   <= r_s2_have;
            r_s4_have   <= r_s3_have;
            r_out_valid <= r_s4_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= i_top;
            r_win[5] <= i_mid;
            r_win[8] <= i_pix;
            r_w_cls  <= i_cls;
        end
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r_rs[r] <= term[r*3] + term[r*3+1] + term[r*3+2];
            end
            r_s2_last <= r_w_cls.last;
            r_acc     <= r_rs[0] + r_rs[1] + r_rs[2];
            r_s3_last <= r_s2_last;
            // divide by nine as multiply by reciprocal
            r_prod    <= PW'(r_acc[KW-1:0]) * PW'(DIV_M);
            r_acc4    <= r_acc;
            r_s4_last <= r_s3_last;
            if (r_s4_have) begin
                r_out_value <= ext[CONV_W-1:0];
                r_out_last  <= r_s4_last;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_conv_value = signed'(r_out_value);
    assign o_frame_end  = r_out_last;

endmodule

// ===== hdl/conv3x3_zero_pad_preset_core.sv =====
// Throughput: one beat per clock unless a long output stall fills the beat queue.
// Path: a result leaves once the beat that completes its 3x3 neighborhood
//   (N+1 beats after the center pixel) has passed the row-store read, the beat
//   queue and the back-end window, row-sum, sum, product and output registers.
// Reset: synchronous active low; clears counters, queue and pipeline valids,
//   kernel_mode to 0 and image_size to 8. Row stores are not cleared.
// ----------------------------------------------------------------------------
// 3x3 zero-padded convolution - top level
// Streaming same-size 3x3 convolution with preset kernels, config registers
// and a decoupled front end / back end joined by a short beat queue.
// ----------------------------------------------------------------------------
module conv3x3_zero_pad_preset_core #(
    parameter int MAX_SIZE   = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [c3zp_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [c3zp_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [PIXEL_BITS-1:0]                i_pixel,
    input  logic                                 i_is_flush,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [c3zp_pkg::CONV_W-1:0]   o_conv_value,
    output logic                                 o_frame_end
);
    import c3zp_pkg::*;

    localparam int P  = PIXEL_BITS;
    localparam int QW = 3*P + $bits(t_cls);

    t_kernel_mode      r_kernel_mode;
    logic [CFG_W-1:0]  r_image_size;
    logic              restart;

    logic              f_valid, f_ready;
    logic [P-1:0]      f_top, f_mid, f_pix;
    t_cls              f_cls;

    logic              q_valid, q_ready;
    logic [QW-1:0]     q_in, q_out;
    logic [P-1:0]      b_top, b_mid, b_pix;
    t_cls              b_cls;

    assign restart = i_cfg_we && (i_cfg_index == REG_IMAGE_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mode <= KM_VERT;
            r_image_size  <= IMAGE_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KERNEL_MODE: r_kernel_mode <= t_kernel_mode'(i_cfg_data[MODE_W-1:0]);
                REG_IMAGE_SIZE:  r_image_size  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    c3zp_front #(
        .MAX_SIZE   (MAX_SIZE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_image_size (r_image_size),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .i_is_flush   (i_is_flush),
        .o_valid      (f_valid),
        .i_ready      (f_ready),
        .o_top        (f_top),
        .o_mid        (f_mid),
        .o_pix        (f_pix),
        .o_cls        (f_cls)
    );

    assign q_in = {f_top, f_mid, f_pix, f_cls};

    c3zp_fifo #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_in),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_out)
    );

    assign {b_top, b_mid, b_pix, b_cls} = q_out;

    c3zp_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_kernel_mode),
        .i_valid      (q_valid),
        .o_ready      (q_ready),
        .i_top        (b_top),
        .i_mid        (b_mid),
        .i_pix        (b_pix),
        .i_cls        (b_cls),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_conv_value (o_conv_value),
        .o_frame_end  (o_frame_end)
    );

endmodule

// ===== hdl/c3zp_checker.sv =====
// ----------------------------------------------------------------------------
// 3x3 zero-padded convolution - port checker
// Watches the top-level ports: output beat hold, state right after reset and
// the minimum pipeline depth after reset.
// ----------------------------------------------------------------------------
module c3zp_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic signed [c3zp_pkg::CONV_W-1:0]   o_conv_value,
    input logic                                 o_frame_end
);
    import c3zp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_conv_value) && $stable(o_frame_end))
        else $error("output beat changed while stalled");

    a_post_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid && o_ready)
        else $error("block not empty and ready after reset");

    a_min_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_rst_n, 4) && $past(i_rst_n, 2))
        else $error("result appeared too soon after reset");

endmodule

bind conv3x3_zero_pad_preset_core c3zp_checker u_chk (.*);

// ===== tb/sv/tb_conv3x3_zero_pad_preset_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3x3 zero-padded convolution - self-checking testbench
// Streams frames of pixels and flush beats through the core with random
// idling on both sides. A beat-level model of the line buffers and the window
// predicts every result, and each result is checked against it in order.
// Kernel and image size are rewritten between and within frames, extremes included.
// ----------------------------------------------------------------------------
module tb_conv3x3_zero_pad_preset_core;
    import c3zp_pkg::*;

    localparam int MAX_PIX   = 1024;
    localparam int QUIET_CYC = 24;
    localparam int END_CYC   = 32;
    localparam int LIMIT_CYC = 500000;
    localparam int RAND_BEATS = 1000;

    typedef enum logic [1:0] {
        CMD_BEAT,
        CMD_CFG,
        CMD_DRAIN
    } t_cmd_kind;

    typedef struct {
        t_cmd_kind        kind;
        logic [7:0]       pixel;
        logic             flush;
        logic [IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0] reg_data;
        int unsigned      gap_pct;
        int unsigned      stall_pct;
    } t_cmd;

    typedef struct packed {
        logic signed [CONV_W-1:0] value;
        logic                     frame_end;
    } t_conv_res;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_W-1:0]         i_cfg_data  = '0;
    logic                     i_valid     = 1'b0;
    logic [7:0]               i_pixel     = '0;
    logic                     i_is_flush  = 1'b0;
    logic                     i_ready     = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic signed [CONV_W-1:0] o_conv_value;
    logic                     o_frame_end;

    conv3x3_zero_pad_preset_core #(
        .MAX_SIZE   (MAX_PIX),
        .PIXEL_BITS (8)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .i_is_flush   (i_is_flush),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_conv_value (o_conv_value),
        .o_frame_end  (o_frame_end)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    t_kernel_mode     mdl_mode = KM_VERT;
    logic [CFG_W-1:0] mdl_size = IMAGE_SIZE_RST;
    logic [7:0]       line_up [MAX_PIX];
    logic [7:0]       line_lo [MAX_PIX];
    logic [7:0]       win [9];
    int unsigned      pos_col = 0;
    int unsigned      pos_row = 0;

    t_conv_res   conv_expected_q [$];
    t_cmd        pending_q [$];
    int unsigned cycle_cnt  = 0;
    int          err_count  = 0;
    int unsigned gap_left   = 0;
    int unsigned quiet_cnt  = 0;
    int unsigned stall_pct  = 0;
    int unsigned stall_left = 0;
    int unsigned cur_gap    = 0;
    int unsigned cur_stall  = 0;
    int unsigned beat_total = 0;

    function automatic int kern_coef(t_kernel_mode m, int k);
        int c;
        case (m)
            KM_VERT:  c = (k % 3 == 0) ? -1 : ((k % 3 == 2) ? 1 : 0);
            KM_HORZ:  c = (k < 3) ? -1 : ((k > 5) ? 1 : 0);
            KM_SHARP: c = (k == 4) ? 5 : ((k % 2 == 1) ? -1 : 0);
            default:  c = 1;
        endcase
        return c;
    endfunction

    task automatic conv_predict(input logic [7:0] pix, input logic flush);
        int unsigned n, p, col, row, idx, top, mid, cr, cc;
        int          acc;
        logic        last;
        t_conv_res   res;
        n   = (mdl_size == 0) ? 1 : ((mdl_size > MAX_PIX) ? MAX_PIX : mdl_size);
        p   = flush ? 0 : pix;
        col = pos_col;
        row = pos_row;
        idx = col % MAX_PIX;
        top = line_up[idx];
        mid = line_lo[idx];
        line_up[idx] = mid[7:0];
        line_lo[idx] = p[7:0];
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = top[7:0];
        win[5] = mid[7:0];
        win[8] = p[7:0];
        last = 1'b0;
        if ((row >= 1 && col >= 1) || row >= 2) begin
            if (col >= 1) begin
                cr = row - 1;
                cc = col - 1;
            end else begin
                cr = row - 2;
                cc = n - 1;
            end
            acc = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if ((r == 0 && cr == 0) || (r == 2 && cr == n - 1) ||
                        (c == 0 && cc == 0) || (c == 2 && cc == n - 1))
                        continue;
                    acc += kern_coef(mdl_mode, r*3 + c) * int'(win[r*3 + c]);
                end
            end
            if (mdl_mode == KM_BLUR) acc = acc / 9;
            last = (cr == n - 1) && (cc == n - 1);
            res.value     = acc[CONV_W-1:0];
            res.frame_end = last;
            conv_expected_q.push_back(res);
        end
        if (last) begin
            pos_col = 0;
            pos_row = 0;
        end else begin
            col++;
            if (col >= n) begin
                col = 0;
                row++;
            end
            pos_col = col;
            pos_row = row & 32'h7FF;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_cmd c;
        logic nxt_valid;
        logic we;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            if (i_valid && o_ready) conv_predict(i_pixel, i_is_flush);
            nxt_valid = i_valid && !o_ready;
            we = 1'b0;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    c = pending_q[0];
                    case (c.kind)
                        CMD_BEAT: begin
                            nxt_valid = 1'b1;
                            i_pixel    <= c.pixel;
                            i_is_flush <= c.flush;
                            stall_pct  <= c.stall_pct;
                            if ($urandom_range(99) < c.gap_pct) gap_left = $urandom_range(11, 1);
                            void'(pending_q.pop_front());
                        end
                        CMD_CFG: begin
                            we = 1'b1;
                            i_cfg_index <= c.reg_idx;
                            i_cfg_data  <= c.reg_data;
                            if (c.reg_idx == REG_KERNEL_MODE) begin
                                mdl_mode = t_kernel_mode'(c.reg_data[MODE_W-1:0]);
                            end else begin
                                mdl_size = c.reg_data;
                                pos_col  = 0;
                                pos_row  = 0;
                            end
                            void'(pending_q.pop_front());
                        end
                        default: begin
                            if (conv_expected_q.size() == 0) begin
                                if (quiet_cnt >= QUIET_CYC) begin
                                    quiet_cnt = 0;
                                    void'(pending_q.pop_front());
                                end else begin
                                    quiet_cnt++;
                                end
                            end else begin
                                quiet_cnt = 0;
                            end
                        end
                    endcase
                end
            end
            i_valid  <= nxt_valid;
            i_cfg_we <= we;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_conv_res want;
        logic      rdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (conv_expected_q.size() == 0) begin
                    $error("unexpected beat: conv_value %0d frame_end %0b",
                           o_conv_value, o_frame_end);
                    err_count++;
                end else begin
                    want = conv_expected_q.pop_front();
                    if (o_conv_value !== want.value) begin
                        $error("conv_value: expected %0d, actual %0d", want.value, o_conv_value);
                        err_count++;
                    end
                    if (o_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, actual %0b",
                               want.frame_end, o_frame_end);
                        err_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if ($urandom_range(99) < stall_pct) begin
                stall_left = $urandom_range(10, 0);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_ready <= rdy;
        end
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        while (cycle_cnt < LIMIT_CYC) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] rand_pixel();
        logic [7:0] v;
        case ($urandom_range(3))
            0:       v = 8'hFF;
            1:       v = 8'h00;
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    task automatic queue_cmd(t_cmd_kind kind, logic [7:0] pix, logic flush,
                             logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        t_cmd c;
        c.kind      = kind;
        c.pixel     = pix;
        c.flush     = flush;
        c.reg_idx   = idx;
        c.reg_data  = data;
        c.gap_pct   = cur_gap;
        c.stall_pct = cur_stall;
        pending_q.push_back(c);
        if (kind == CMD_BEAT) beat_total++;
    endtask

    task automatic queue_beat(logic [7:0] pix, logic flush);
        queue_cmd(CMD_BEAT, pix, flush, '0, '0);
    endtask

    task automatic queue_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        queue_cmd(CMD_DRAIN, '0, 1'b0, '0, '0);
        queue_cmd(CMD_CFG, '0, 1'b0, idx, data);
    endtask

    task automatic queue_mode(t_kernel_mode m);
        logic [CFG_W-1:0] d;
        d = CFG_W'($urandom);
        d[MODE_W-1:0] = m;
        queue_reg(REG_KERNEL_MODE, d);
    endtask

    task automatic queue_frame(int unsigned n);
        for (int unsigned i = 0; i < n * n; i++)
            queue_beat(rand_pixel(), $urandom_range(19) == 0);
        for (int unsigned i = 0; i <= n; i++)
            queue_beat(8'($urandom), 1'b1);
    endtask

    initial begin
        logic [CFG_W-1:0] sz;
        int unsigned      cur_n;
        int unsigned      dir_end;
        int unsigned      kind;
        bit               large_done;
        for (int i = 0; i < MAX_PIX; i++) begin
            line_up[i] = '0;
            line_lo[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;

        // single-pixel frames, back to back, size 0 acting as 1
        queue_mode(KM_SHARP);
        queue_reg(REG_IMAGE_SIZE, '0);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'($urandom), 1'b1);
        queue_beat(8'($urandom), 1'b1);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'($urandom), 1'b1);
        queue_beat(8'($urandom), 1'b1);
        // 2x2 with a flush beat inside the image
        queue_mode(KM_HORZ);
        queue_reg(REG_IMAGE_SIZE, 11'd2);
        queue_beat(8'hFF, 1'b0);
        queue_beat(8'hFF, 1'b1);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'hFF, 1'b0);
        repeat (3) queue_beat(8'($urandom), 1'b1);
        // 3x3, kernel changed mid-frame, sharpen minimum at the center
        queue_mode(KM_BLUR);
        queue_reg(REG_IMAGE_SIZE, 11'd3);
        repeat (4) queue_beat(8'hFF, 1'b0);
        queue_beat(8'h00, 1'b0);
        repeat (2) queue_beat(8'hFF, 1'b0);
        queue_mode(KM_SHARP);
        repeat (2) queue_beat(8'hFF, 1'b0);
        repeat (4) queue_beat(8'($urandom), 1'b1);
        dir_end = beat_total;

        cur_n = 3;
        large_done = 1'b0;
        while (beat_total < dir_end + RAND_BEATS) begin
            case ($urandom_range(3))
                0:       cur_gap = 0;
                1:       cur_gap = 10;
                2:       cur_gap = 30;
                default: cur_gap = 60;
            endcase
            case ($urandom_range(3))
                0:       cur_stall = 0;
                1:       cur_stall = 10;
                2:       cur_stall = 30;
                default: cur_stall = 60;
            endcase
            if (!large_done && beat_total > dir_end + 400) begin
                large_done = 1'b1;
                queue_mode(t_kernel_mode'($urandom_range(3)));
                queue_reg(REG_IMAGE_SIZE, 11'h7FF);
                repeat (1100) queue_beat(rand_pixel(), $urandom_range(19) == 0);
                queue_reg(REG_IMAGE_SIZE, 11'd1024);
                repeat (20) queue_beat(rand_pixel(), 1'b0);
            end
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(19))
                    0:       sz = 11'd0;
                    1:       sz = 11'd1;
                    2, 3:    sz = CFG_W'($urandom_range(32, 13));
                    default: sz = CFG_W'($urandom_range(12, 2));
                endcase
                cur_n = (sz == 0) ? 1 : sz;
                queue_reg(REG_IMAGE_SIZE, sz);
            end
            if ($urandom_range(1) != 0) queue_mode(t_kernel_mode'($urandom_range(3)));
            kind = $urandom_range(9);
            case (kind)
                7: repeat ($urandom_range(3 * cur_n, 1))
                       queue_beat(8'($urandom), $urandom_range(1) == 0);
                8: repeat ($urandom_range(cur_n * cur_n, 1))
                       queue_beat(rand_pixel(), 1'b0);
                9: begin
                    queue_frame(cur_n);
                    queue_cmd(CMD_DRAIN, '0, 1'b0, '0, '0);
                    queue_frame(cur_n);
                end
                default: repeat ($urandom_range(3, 1)) queue_frame(cur_n);
            endcase
        end

        // closing frames with no idling
        cur_gap   = 0;
        cur_stall = 0;
        sz = CFG_W'($urandom_range(8, 2));
        queue_reg(REG_IMAGE_SIZE, sz);
        queue_mode(t_kernel_mode'($urandom_range(3)));
        repeat (2) queue_frame(sz);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || i_valid || conv_expected_q.size() > 0)
            @(posedge i_clk);
        repeat (END_CYC) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
